// ===== rtl/egcd_pkg.sv =====
// Package for the extended GCD unit.
// Holds the sequencer state type shared by the top level; no dependencies.
package egcd_pkg;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_FINISH = 5'b10000
    } egcd_state_t;

endpackage

// ===== rtl/egcd_step.sv =====
// One restoring-division step with shift-add quotient products for the extended GCD unit.
// Purely combinational; used once per cycle in the division state by the sequencer in extended_gcd_unit_top.
module egcd_step #(
    parameter int W  = 31,
    parameter int CW = 32
) (
    input  logic [W-1:0]  rem,
    input  logic [W-1:0]  dq,
    input  logic [W-1:0]  divisor,
    input  logic [CW-1:0] xc,
    input  logic [CW-1:0] yc,
    input  logic [CW-1:0] accx,
    input  logic [CW-1:0] accy,
    output logic [W-1:0]  rem_out,
    output logic [W-1:0]  dq_out,
    output logic [CW-1:0] accx_out,
    output logic [CW-1:0] accy_out
);

    logic [W:0] trial;
    logic [W:0] diff;
    logic       qbit;

    // The partial remainder stays below the divisor, so the trial value is below
    // twice the divisor and one subtract settles each quotient bit.
    assign trial = {rem, dq[W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign qbit  = ~diff[W];

    assign rem_out = qbit ? diff[W-1:0] : trial[W-1:0];
    assign dq_out  = {dq[W-2:0], qbit};

    // Quotient bits arrive MSB first, so q*xc builds up by doubling and adding.
    assign accx_out = {accx[CW-2:0], 1'b0} + (qbit ? xc : '0);
    assign accy_out = {accy[CW-2:0], 1'b0} + (qbit ? yc : '0);

endmodule

// ===== rtl/extended_gcd_unit_top.sv =====
// Top level of the extended GCD unit: sequencer, operand and coefficient registers,
// output register. Depends on egcd_pkg and egcd_step.
//
//  channel | ports                                      | dir | beat
//  input   | s_valid s_ready s_a_value s_b_value        | in  | one operand pair
//  result  | m_valid m_ready m_gcd_value m_coef_a/b     | out | gcd and Bezout pair
//
// Each Euclid round runs OPERAND_WIDTH steps of the single restoring-division step,
// then an update state and a zero check. An item is accepted in idle, runs its rounds
// and then loads the output register in the finish state.
// Reset is synchronous and active low and clears only control state.
// The next pair is accepted while a finished result waits in the output register.
module extended_gcd_unit_top #(
    parameter int OPERAND_WIDTH = 31
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [OPERAND_WIDTH-1:0]   s_a_value,
    input  logic [OPERAND_WIDTH-1:0]   s_b_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [OPERAND_WIDTH-1:0]   m_gcd_value,
    output logic signed [OPERAND_WIDTH:0] m_coef_a,
    output logic signed [OPERAND_WIDTH:0] m_coef_b
);

    localparam int W     = OPERAND_WIDTH;
    localparam int CW    = OPERAND_WIDTH + 1;
    localparam int CNT_W = $clog2(OPERAND_WIDTH);

    egcd_pkg::egcd_state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     a_reg, a_next;
    logic [W-1:0]     b_reg, b_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dq_reg, dq_next;
    logic [CW-1:0]    xp_reg, xp_next, xc_reg, xc_next;
    logic [CW-1:0]    yp_reg, yp_next, yc_reg, yc_next;
    logic [CW-1:0]    accx_reg, accx_next, accy_reg, accy_next;

    logic             m_valid_reg, m_valid_next;
    logic [W-1:0]     gcd_reg, gcd_next;
    logic [CW-1:0]    coefa_reg, coefa_next, coefb_reg, coefb_next;

    logic [W-1:0]     step_rem, step_dq;
    logic [CW-1:0]    step_accx, step_accy;

    egcd_step #(
        .W  (W),
        .CW (CW)
    ) u_step (
        .rem      (rem_reg),
        .dq       (dq_reg),
        .divisor  (b_reg),
        .xc       (xc_reg),
        .yc       (yc_reg),
        .accx     (accx_reg),
        .accy     (accy_reg),
        .rem_out  (step_rem),
        .dq_out   (step_dq),
        .accx_out (step_accx),
        .accy_out (step_accy)
    );

    assign s_ready     = (state_reg == egcd_pkg::ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_gcd_value = gcd_reg;
    assign m_coef_a    = coefa_reg;
    assign m_coef_b    = coefb_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        xp_next      = xp_reg;
        xc_next      = xc_reg;
        yp_next      = yp_reg;
        yc_next      = yc_reg;
        accx_next    = accx_reg;
        accy_next    = accy_reg;
        gcd_next     = gcd_reg;
        coefa_next   = coefa_reg;
        coefb_next   = coefb_reg;
        m_valid_next = m_valid_reg & ~m_ready;

        unique case (state_reg)
            egcd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    a_next     = s_a_value;
                    b_next     = s_b_value;
                    xp_next    = CW'(1);
                    xc_next    = '0;
                    yp_next    = '0;
                    yc_next    = CW'(1);
                    state_next = egcd_pkg::ST_CHECK;
                end
            end
            egcd_pkg::ST_CHECK: begin
                if (b_reg == '0) begin
                    state_next = egcd_pkg::ST_FINISH;
                end else begin
                    rem_next   = '0;
                    dq_next    = a_reg;
                    accx_next  = '0;
                    accy_next  = '0;
                    cnt_next   = CNT_W'(OPERAND_WIDTH - 1);
                    state_next = egcd_pkg::ST_DIV;
                end
            end
            egcd_pkg::ST_DIV: begin
                rem_next  = step_rem;
                dq_next   = step_dq;
                accx_next = step_accx;
                accy_next = step_accy;
                if (cnt_reg == '0) begin
                    state_next = egcd_pkg::ST_UPDATE;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            egcd_pkg::ST_UPDATE: begin
                // The accumulators now hold q times the current coefficients.
                a_next     = b_reg;
                b_next     = rem_reg;
                xp_next    = xc_reg;
                xc_next    = xp_reg - accx_reg;
                yp_next    = yc_reg;
                yc_next    = yp_reg - accy_reg;
                state_next = egcd_pkg::ST_CHECK;
            end
            egcd_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    gcd_next     = a_reg;
                    coefa_next   = xp_reg;
                    coefb_next   = yp_reg;
                    m_valid_next = 1'b1;
                    state_next   = egcd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = egcd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= egcd_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        rem_reg   <= rem_next;
        dq_reg    <= dq_next;
        xp_reg    <= xp_next;
        xc_reg    <= xc_next;
        yp_reg    <= yp_next;
        yc_reg    <= yc_next;
        accx_reg  <= accx_next;
        accy_reg  <= accy_next;
        gcd_reg   <= gcd_next;
        coefa_reg <= coefa_next;
        coefb_reg <= coefb_next;
    end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for extended_gcd_unit_top: operand pairs go in, and each gcd and
// Bezout pair that comes out is checked against an in-bench Euclid predictor or a directed row.
// Depends only on the RTL of the unit; no files and no arguments are read.
module tb_top;

    localparam int OPW       = 31;
    localparam int RAND_ITEMS = 402;
    localparam int TAIL_CYCLES = 1600;
    localparam logic [OPW-1:0] OP_MAX = {OPW{1'b1}};

    typedef struct {
        logic [OPW-1:0]      gcd;
        logic signed [OPW:0] coef_a;
        logic signed [OPW:0] coef_b;
    } gcd_triple_t;

    typedef struct {
        logic [OPW-1:0] a;
        logic [OPW-1:0] b;
        bit             typed;
        gcd_triple_t    want;
    } directed_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OPW-1:0] s_a_value = '0;
    logic [OPW-1:0] s_b_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [OPW-1:0] m_gcd_value;
    logic signed [OPW:0] m_coef_a;
    logic signed [OPW:0] m_coef_b;

    gcd_triple_t   pending_triples[$];
    directed_row_t directed_rows[$];
    int            mismatch_count = 0;
    int            tx_idle_pct = 9;
    int            rx_idle_pct = 45;

    always #5 aclk = ~aclk;

    extended_gcd_unit_top #(
        .OPERAND_WIDTH(OPW)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_a_value  (s_a_value),
        .s_b_value  (s_b_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_gcd_value(m_gcd_value),
        .m_coef_a   (m_coef_a),
        .m_coef_b   (m_coef_b)
    );

    // Coefficients are carried as 64-bit two's complement with wrapping, then cut down.
    function automatic gcd_triple_t bezout_of(logic [OPW-1:0] a_in, logic [OPW-1:0] b_in);
        logic [63:0] rem_prev, rem_cur, quot, rem_next;
        logic [63:0] xp, xc, yp, yc, xn, yn;
        gcd_triple_t res;
        rem_prev = 64'(a_in);
        rem_cur  = 64'(b_in);
        xp = 64'd1;
        xc = 64'd0;
        yp = 64'd0;
        yc = 64'd1;
        while (rem_cur != 64'd0) begin
            quot     = rem_prev / rem_cur;
            rem_next = rem_prev - quot * rem_cur;
            xn       = xp - quot * xc;
            yn       = yp - quot * yc;
            rem_prev = rem_cur;
            rem_cur  = rem_next;
            xp = xc;
            xc = xn;
            yp = yc;
            yc = yn;
        end
        res.gcd    = rem_prev[OPW-1:0];
        res.coef_a = xp[OPW:0];
        res.coef_b = yp[OPW:0];
        return res;
    endfunction

    task automatic add_row(logic [OPW-1:0] a, logic [OPW-1:0] b, bit typed,
                           logic [OPW-1:0] g, logic signed [OPW:0] x,
                           logic signed [OPW:0] y);
        directed_row_t row;
        row.a = a;
        row.b = b;
        row.typed = typed;
        row.want.gcd = g;
        row.want.coef_a = x;
        row.want.coef_b = y;
        directed_rows = {directed_rows, row};
    endtask

    // Holds the beat until accepted, queues its expectation, then idles at random.
    task automatic send_pair(logic [OPW-1:0] a, logic [OPW-1:0] b, gcd_triple_t want);
        s_a_value <= a;
        s_b_value <= b;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_triples = {pending_triples, want};
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < tx_idle_pct) @(posedge aclk);
        end
    endtask

    task automatic drain_pending();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_triples.size() != 0) @(posedge aclk);
    endtask

    task automatic pick_pair(output logic [OPW-1:0] a, output logic [OPW-1:0] b);
        logic [63:0] fa, fb, ft, g, m, n;
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            a = OPW'($urandom());
            b = OPW'($urandom());
        end else if (kind < 60) begin
            // Shared factor of 2 to 65535, so the gcd is a multiple of it.
            g = 64'($urandom_range(2, 65535));
            m = 64'($urandom()) % (64'(OP_MAX) / g + 64'd1);
            n = 64'($urandom()) % (64'(OP_MAX) / g + 64'd1);
            a = OPW'(g * m);
            b = OPW'(g * n);
        end else if (kind < 75) begin
            a = OPW'($urandom_range(0, 65535));
            b = OPW'($urandom_range(0, 65535));
        end else if (kind < 85) begin
            // Near-Fibonacci pairs give long chains of unit quotients.
            fa = 64'($urandom_range(1, 4));
            fb = 64'($urandom_range(1, 4));
            repeat ($urandom_range(5, 44)) begin
                ft = fa + fb;
                if (ft > 64'(OP_MAX)) break;
                fa = fb;
                fb = ft;
            end
            if ($urandom_range(0, 1) == 0) begin
                a = OPW'(fb);
                b = OPW'(fa);
            end else begin
                a = OPW'(fa);
                b = OPW'(fb);
            end
        end else begin
            case ($urandom_range(0, 4))
                0: a = '0;
                1: a = OPW'(1);
                2: a = OP_MAX;
                3: a = OP_MAX - OPW'(1);
                default: a = OPW'($urandom());
            endcase
            case ($urandom_range(0, 4))
                0: b = '0;
                1: b = OPW'(1);
                2: b = OP_MAX;
                3: b = OPW'(1) << (OPW - 1);
                default: b = OPW'($urandom());
            endcase
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        gcd_triple_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_triples.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result beat with nothing pending: gcd %0d x %0d y %0d",
                             m_gcd_value, m_coef_a, m_coef_b);
            end else begin
                want = pending_triples.pop_front();
                if (m_gcd_value !== want.gcd || m_coef_a !== want.coef_a
                        || m_coef_b !== want.coef_b) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected gcd %0d x %0d y %0d, got %0d %0d %0d",
                                 want.gcd, want.coef_a, want.coef_b,
                                 m_gcd_value, m_coef_a, m_coef_b);
                end
            end
        end
    end

    initial begin
        logic [OPW-1:0] a, b;
        gcd_triple_t want;

        // Rows whose answer is obvious carry it; the rest go through the predictor.
        add_row('0,     '0,     1, '0,     1, 0);
        add_row('0,     OP_MAX, 1, OP_MAX, 0, 1);
        add_row('0,     5,      1, 5,      0, 1);
        add_row(OP_MAX, '0,     1, OP_MAX, 1, 0);
        add_row(7,      '0,     1, 7,      1, 0);
        add_row(1,      1,      1, 1,      0, 1);
        add_row(OP_MAX, OP_MAX, 1, OP_MAX, 0, 1);
        add_row(OP_MAX, 1,      1, 1,      0, 1);
        add_row(1,      OP_MAX, 0, '0, 0, 0);
        add_row(OP_MAX, OP_MAX - 1, 0, '0, 0, 0);
        add_row(OP_MAX - 1, OP_MAX, 0, '0, 0, 0);
        add_row(1836311903, 1134903170, 0, '0, 0, 0);
        add_row(1134903170, 1836311903, 0, '0, 0, 0);
        add_row(1073741824, 536870912,  0, '0, 0, 0);
        add_row(OP_MAX, 1073741824,     0, '0, 0, 0);
        add_row(240, 46, 0, '0, 0, 0);
        add_row(46, 240, 0, '0, 0, 0);
        add_row(1431655765, 715827882,  0, '0, 0, 0);
        add_row(715827882, 1431655765,  0, '0, 0, 0);
        add_row(12345678, 87654321,     0, '0, 0, 0);
        add_row(2, 3, 0, '0, 0, 0);
        add_row(1000000007, 998244353,  0, '0, 0, 0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            want = directed_rows[i].typed ? directed_rows[i].want
                                          : bezout_of(directed_rows[i].a, directed_rows[i].b);
            send_pair(directed_rows[i].a, directed_rows[i].b, want);
        end

        for (int ph = 0; ph < 3; ph++) begin
            // Let the unit empty out completely before each idling pattern starts.
            drain_pending();
            case (ph)
                0: begin
                    tx_idle_pct = 9;
                    rx_idle_pct = 45;
                end
                1: begin
                    tx_idle_pct = 45;
                    rx_idle_pct = 9;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            repeat (RAND_ITEMS / 3) begin
                pick_pair(a, b);
                send_pair(a, b, bezout_of(a, b));
            end
        end

        drain_pending();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_triples.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/egcd_pkg.sv
rtl/egcd_step.sv
rtl/extended_gcd_unit_top.sv
verif/tb_top.sv
